FILE: sv/audio_rift_analyzer_core_defines.svh
`ifndef AUDIO_RIFT_ANALYZER_CORE_DEFINES_SVH
`define AUDIO_RIFT_ANALYZER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ARA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define ARA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/ara_pkg.sv
`timescale 1ns / 1ps

package ara_pkg;

    localparam logic [1:0] OP_WRITE_A     = 2'd0;
    localparam logic [1:0] OP_WRITE_B     = 2'd1;
    localparam logic [1:0] OP_ANALYZE_FWD = 2'd2;
    localparam logic [1:0] OP_ANALYZE_REV = 2'd3;

    localparam int PW = 18;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_CASE_SEL = 9'b000000010,
        ST_CHK_RD   = 9'b000000100,
        ST_CHK_CMP  = 9'b000001000,
        ST_RIFT_SET = 9'b000010000,
        ST_RIFT_RD  = 9'b000100000,
        ST_RIFT_CMP = 9'b001000000,
        ST_RESULT   = 9'b010000000,
        ST_FOUND    = 9'b100000000
    } state_t;

    typedef enum logic [1:0] {
        CS_B_SHIFT = 2'd0,
        CS_A_SHIFT = 2'd1,
        CS_BOTH    = 2'd2
    } case_t;

endpackage

FILE: sv/audio_rift_analyzer_core.sv
`timescale 1ns / 1ps
// Sample-buffer rift analyzer. Write transactions (opcode 0/1) load one sample into store A
// or B. An analyze transaction (opcode 2 forward, 3 reverse) runs a sequencer around one
// shared compare unit and the single read port of each store: every candidate shift has a
// setup step followed by a read and a compare per agreeing sample (up to min_run), and a
// stutter check reads and compares each rift sample. in_stall is high for the whole search;
// one result transaction is produced per analyze transaction and none per write.

module audio_rift_analyzer_core #(
    parameter int BUFFER_SAMPLES = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic [11:0]        index,
    input  logic signed [15:0] sample,
    input  logic [12:0]        size_a,
    input  logic [12:0]        size_b,
    input  logic [11:0]        offset_a,
    input  logic [11:0]        offset_b,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [13:0] match_a,
    output logic signed [13:0] match_b,
    output logic [12:0]        match_c,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [12:0]        cfg_min_run
);

`include "audio_rift_analyzer_core_defines.svh"

    localparam int AW = $clog2(BUFFER_SAMPLES);
    localparam int PW = ara_pkg::PW;
    localparam logic signed [PW-1:0] BUF_LIM = PW'(BUFFER_SAMPLES);
    localparam logic signed [PW-1:0] P_ONE   = PW'(1);

    ara_pkg::state_t state_reg, state_next;
    ara_pkg::case_t  cs_reg, cs_next;

    logic signed [PW-1:0] i_reg, i_next;
    logic signed [PW-1:0] pa_reg, pa_next, pb_reg, pb_next;
    logic signed [PW-1:0] rem_reg, rem_next;
    logic signed [PW-1:0] sa_reg, sa_next, sb_reg, sb_next;
    logic signed [PW-1:0] oa_reg, oa_next, ob_reg, ob_next;
    logic signed [PW-1:0] apast_reg, apast_next, bpast_reg, bpast_next;
    logic [12:0]          n_reg, n_next;
    logic                 rev_reg, rev_next;
    logic signed [13:0]   res_a_reg, res_a_next, res_b_reg, res_b_next;
    logic [12:0]          res_c_reg, res_c_next;
    logic signed [13:0]   out_a_reg, out_b_reg;
    logic [12:0]          out_c_reg;
    logic                 out_valid_reg;
    logic [12:0]          min_run_reg;

    logic [15:0] mem_a [BUFFER_SAMPLES];
    logic [15:0] mem_b [BUFFER_SAMPLES];
    logic [15:0] qa_reg, qb_reg;
    logic        ina_reg, inb_reg;

    logic in_acc, wr_ok, samp_eq, load_out;
    logic wr_op, an_op, rift_cmp;
    logic signed [PW-1:0] sz_a, sz_b, off_a, off_b, delta;
    logic signed [PW-1:0] px, py, px2, py2, gap, gap2, xsize;

    function automatic logic in_range(input logic signed [PW-1:0] p);
        in_range = (p >= 0) && (p < BUF_LIM);
    endfunction

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ara_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == ara_pkg::ST_IDLE);
    assign wr_ok     = $signed(PW'(index)) < BUF_LIM;
    assign samp_eq   = ((ina_reg ? qa_reg : 16'd0) == (inb_reg ? qb_reg : 16'd0));
    assign load_out  = (state_reg == ara_pkg::ST_RESULT) && (!out_valid_reg || !out_stall);
    assign wr_op     = (opcode == ara_pkg::OP_WRITE_A) || (opcode == ara_pkg::OP_WRITE_B);
    assign an_op     = (opcode == ara_pkg::OP_ANALYZE_FWD) || (opcode == ara_pkg::OP_ANALYZE_REV);
    assign rift_cmp  = (state_reg == ara_pkg::ST_RIFT_CMP);

    assign out_valid = out_valid_reg;
    assign match_a   = out_a_reg;
    assign match_b   = out_b_reg;
    assign match_c   = out_c_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc && opcode == ara_pkg::OP_WRITE_A && wr_ok)
        begin
            mem_a[AW'(index)] <= sample;
        end
        if (in_acc && opcode == ara_pkg::OP_WRITE_B && wr_ok)
        begin
            mem_b[AW'(index)] <= sample;
        end
        qa_reg  <= mem_a[pa_reg[AW-1:0]];
        qb_reg  <= mem_b[pb_reg[AW-1:0]];
        ina_reg <= in_range(pa_reg);
        inb_reg <= in_range(pb_reg);
    end

    always_comb
    begin
        sz_a  = ($signed(PW'(size_a)) > BUF_LIM) ? BUF_LIM : $signed(PW'(size_a));
        sz_b  = ($signed(PW'(size_b)) > BUF_LIM) ? BUF_LIM : $signed(PW'(size_b));
        off_a = $signed(PW'(offset_a));
        off_b = $signed(PW'(offset_b));
        delta = rev_reg ? -i_reg : i_reg;

        if (cs_reg == ara_pkg::CS_B_SHIFT)
        begin
            px    = rev_reg ? oa_reg + P_ONE : oa_reg - i_reg;
            py    = rev_reg ? ob_reg - i_reg + P_ONE : ob_reg;
            xsize = sa_reg;
        end
        else
        begin
            px    = rev_reg ? ob_reg + P_ONE : ob_reg - i_reg;
            py    = rev_reg ? oa_reg - i_reg + P_ONE : oa_reg;
            xsize = sb_reg;
        end
        if (px < 0)
        begin
            py2 = py - px;
            gap = i_reg + px;
            px2 = '0;
        end
        else
        begin
            py2 = py;
            gap = i_reg;
            px2 = px;
        end
        gap2 = (gap > xsize - px2) ? xsize - px2 : gap;
    end

    always_comb
    begin
        state_next = state_reg;
        cs_next    = cs_reg;
        i_next     = i_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        rem_next   = rem_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        oa_next    = oa_reg;
        ob_next    = ob_reg;
        apast_next = apast_reg;
        bpast_next = bpast_reg;
        n_next     = n_reg;
        rev_next   = rev_reg;
        res_a_next = res_a_reg;
        res_b_next = res_b_reg;
        res_c_next = res_c_reg;

        unique case (state_reg)
            ara_pkg::ST_IDLE:
            begin
                if (in_acc && an_op)
                begin
                    rev_next   = (opcode == ara_pkg::OP_ANALYZE_REV);
                    sa_next    = sz_a;
                    sb_next    = sz_b;
                    oa_next    = off_a;
                    ob_next    = off_b;
                    apast_next = rev_next ? off_a + P_ONE : sz_a - off_a;
                    bpast_next = rev_next ? off_b + P_ONE : sz_b - off_b;
                    i_next     = '0;
                    cs_next    = ara_pkg::CS_B_SHIFT;
                    res_a_next = '0;
                    res_b_next = '0;
                    res_c_next = '0;
                    state_next = ara_pkg::ST_CASE_SEL;
                end
            end
            ara_pkg::ST_CASE_SEL:
            begin
                pa_next = (cs_reg == ara_pkg::CS_B_SHIFT) ? oa_reg : oa_reg + delta;
                pb_next = (cs_reg == ara_pkg::CS_A_SHIFT) ? ob_reg : ob_reg + delta;
                n_next  = '0;
                case (cs_reg)
                    ara_pkg::CS_B_SHIFT:
                    begin
                        if (i_reg < bpast_reg)
                        begin
                            state_next = ara_pkg::ST_CHK_RD;
                        end
                        else
                        begin
                            cs_next = ara_pkg::CS_A_SHIFT;
                        end
                    end
                    ara_pkg::CS_A_SHIFT:
                    begin
                        if (i_reg < apast_reg)
                        begin
                            state_next = ara_pkg::ST_CHK_RD;
                        end
                        else if (i_reg >= bpast_reg)
                        begin
                            state_next = ara_pkg::ST_RESULT;
                        end
                        else
                        begin
                            i_next  = i_reg + P_ONE;
                            cs_next = ara_pkg::CS_B_SHIFT;
                        end
                    end
                    default:
                    begin
                        if (i_reg < bpast_reg)
                        begin
                            state_next = ara_pkg::ST_CHK_RD;
                        end
                        else
                        begin
                            i_next  = i_reg + P_ONE;
                            cs_next = ara_pkg::CS_B_SHIFT;
                        end
                    end
                endcase
            end
            ara_pkg::ST_CHK_RD:
            begin
                if (n_reg >= min_run_reg)
                begin
                    state_next = ara_pkg::ST_FOUND;
                end
                else if (rev_reg ? (pa_reg >= 0 && pb_reg >= 0)
                                 : (pa_reg < sa_reg && pb_reg < sb_reg))
                begin
                    state_next = ara_pkg::ST_CHK_CMP;
                end
                else
                begin
                    state_next = ara_pkg::ST_CASE_SEL;
                    if (cs_reg == ara_pkg::CS_B_SHIFT)
                    begin
                        cs_next = ara_pkg::CS_A_SHIFT;
                    end
                    else if (cs_reg == ara_pkg::CS_A_SHIFT)
                    begin
                        cs_next = ara_pkg::CS_BOTH;
                    end
                    else
                    begin
                        cs_next = ara_pkg::CS_B_SHIFT;
                        i_next  = i_reg + P_ONE;
                    end
                end
            end
            ara_pkg::ST_CHK_CMP:
            begin
                if (samp_eq)
                begin
                    n_next  = n_reg + 13'd1;
                    pa_next = rev_reg ? pa_reg - P_ONE : pa_reg + P_ONE;
                    pb_next = rev_reg ? pb_reg - P_ONE : pb_reg + P_ONE;
                    state_next = ara_pkg::ST_CHK_RD;
                end
                else
                begin
                    state_next = ara_pkg::ST_CASE_SEL;
                    if (cs_reg == ara_pkg::CS_B_SHIFT)
                    begin
                        cs_next = ara_pkg::CS_A_SHIFT;
                    end
                    else if (cs_reg == ara_pkg::CS_A_SHIFT)
                    begin
                        cs_next = ara_pkg::CS_BOTH;
                    end
                    else
                    begin
                        cs_next = ara_pkg::CS_B_SHIFT;
                        i_next  = i_reg + P_ONE;
                    end
                end
            end
            ara_pkg::ST_FOUND:
            begin
                if (cs_reg == ara_pkg::CS_B_SHIFT)
                begin
                    res_a_next = i_reg[13:0];
                end
                else if (cs_reg == ara_pkg::CS_A_SHIFT)
                begin
                    res_b_next = i_reg[13:0];
                end
                else
                begin
                    res_c_next = i_reg[12:0];
                end
                if (cs_reg == ara_pkg::CS_BOTH || i_reg == 0)
                begin
                    state_next = ara_pkg::ST_RESULT;
                end
                else
                begin
                    state_next = ara_pkg::ST_RIFT_SET;
                end
            end
            ara_pkg::ST_RIFT_SET:
            begin
                pa_next    = (cs_reg == ara_pkg::CS_B_SHIFT) ? px2 : py2;
                pb_next    = (cs_reg == ara_pkg::CS_B_SHIFT) ? py2 : px2;
                rem_next   = gap2;
                state_next = ara_pkg::ST_RIFT_RD;
            end
            ara_pkg::ST_RIFT_RD:
            begin
                if (rem_reg <= 0)
                begin
                    if (cs_reg == ara_pkg::CS_B_SHIFT)
                    begin
                        res_b_next = -i_reg[13:0];
                        res_a_next = '0;
                    end
                    else
                    begin
                        res_a_next = -i_reg[13:0];
                        res_b_next = '0;
                    end
                    state_next = ara_pkg::ST_RESULT;
                end
                else
                begin
                    state_next = ara_pkg::ST_RIFT_CMP;
                end
            end
            ara_pkg::ST_RIFT_CMP:
            begin
                if (samp_eq)
                begin
                    pa_next    = pa_reg + P_ONE;
                    pb_next    = pb_reg + P_ONE;
                    rem_next   = rem_reg - P_ONE;
                    state_next = ara_pkg::ST_RIFT_RD;
                end
                else
                begin
                    state_next = ara_pkg::ST_RESULT;
                end
            end
            ara_pkg::ST_RESULT:
            begin
                if (load_out)
                begin
                    state_next = ara_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ara_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ara_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            min_run_reg   <= 13'd16;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                min_run_reg <= cfg_min_run;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cs_reg    <= cs_next;
        i_reg     <= i_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        rem_reg   <= rem_next;
        sa_reg    <= sa_next;
        sb_reg    <= sb_next;
        oa_reg    <= oa_next;
        ob_reg    <= ob_next;
        apast_reg <= apast_next;
        bpast_reg <= bpast_next;
        n_reg     <= n_next;
        rev_reg   <= rev_next;
        res_a_reg <= res_a_next;
        res_b_reg <= res_b_next;
        res_c_reg <= res_c_next;
        if (load_out)
        begin
            out_a_reg <= res_a_reg;
            out_b_reg <= res_b_reg;
            out_c_reg <= res_c_reg;
        end
    end

    `ARA_ASSERT_NOW(a_result_source, $rose(out_valid), $past(state_reg == ara_pkg::ST_RESULT))
    `ARA_ASSERT_NEXT(a_write_stays_idle, in_acc && wr_op, state_reg == ara_pkg::ST_IDLE)
    `ARA_ASSERT_NEXT(a_analyze_starts, in_acc && an_op, state_reg == ara_pkg::ST_CASE_SEL)
    `ARA_ASSERT_NOW(a_rift_nonzero, rift_cmp, i_reg != 0 && cs_reg != ara_pkg::CS_BOTH)

endmodule

FILE: dv/audio_rift_analyzer_core_test.sv
`timescale 1ns / 1ps

module audio_rift_analyzer_core_test;

    localparam int DEPTH = 4096;

    typedef struct packed {
        logic signed [13:0] miss_a;
        logic signed [13:0] miss_b;
        logic [12:0]        garbage;
    } rift_result_t;

    class rift_scoreboard;
        logic [15:0]  store_a [DEPTH];
        logic [15:0]  store_b [DEPTH];
        logic [12:0]  min_run = 13'd16;
        rift_result_t expected_rifts [$];
        int           errors = 0;

        function int rd(bit from_a, int k);
            if (k < 0 || k >= DEPTH)
                return 0;
            return from_a ? int'(store_a[k]) : int'(store_b[k]);
        endfunction

        function int agree_fwd(int pa, int pb, int sa, int sb);
            int n;
            n = 0;
            while (pa < sa && pb < sb && rd(1, pa) == rd(0, pb))
            begin
                pa++; pb++; n++;
            end
            return n;
        endfunction

        function int agree_rev(int pa, int pb);
            int n;
            n = 0;
            while (pa >= 0 && pb >= 0 && rd(1, pa) == rd(0, pb))
            begin
                pa--; pb--; n++;
            end
            return n;
        endfunction

        // x is A when x_is_a, else B; y is the other store
        function bit rift_differs(bit x_is_a, int px, int py, int gap, int xsize);
            if (px < 0)
            begin
                py -= px;
                gap += px;
                px = 0;
            end
            if (gap > xsize - px)
                gap = xsize - px;
            for (int k = 0; k < gap; k++)
                if (rd(x_is_a, px + k) != rd(!x_is_a, py + k))
                    return 1;
            return 0;
        endfunction

        function rift_result_t locate_rift(bit rev, int sa, int sb, int oa, int ob);
            int apast, bpast, need, n, ma, mb, mc;
            bit d;
            rift_result_t r;
            ma = 0; mb = 0; mc = 0;
            need = int'(min_run);
            if (sa > DEPTH) sa = DEPTH;
            if (sb > DEPTH) sb = DEPTH;
            if (rev)
            begin
                apast = oa + 1; bpast = ob + 1;
            end
            else
            begin
                apast = sa - oa; bpast = sb - ob;
            end
            for (int i = 0; ; i++)
            begin
                if (i < bpast)
                begin
                    n = rev ? agree_rev(oa, ob - i) : agree_fwd(oa, ob + i, sa, sb);
                    if (n >= need)
                    begin
                        ma = i; break;
                    end
                end
                if (i < apast)
                begin
                    n = rev ? agree_rev(oa - i, ob) : agree_fwd(oa + i, ob, sa, sb);
                    if (n >= need)
                    begin
                        mb = i; break;
                    end
                    if (i < bpast)
                    begin
                        n = rev ? agree_rev(oa - i, ob - i) : agree_fwd(oa + i, ob + i, sa, sb);
                        if (n >= need)
                        begin
                            mc = i; break;
                        end
                    end
                end
                else if (i >= bpast)
                    break;
            end
            if (mc == 0 && ma != 0)
            begin
                d = rev ? rift_differs(1, oa + 1, ob - ma + 1, ma, sa)
                        : rift_differs(1, oa - ma, ob, ma, sa);
                if (!d)
                begin
                    mb = -ma; ma = 0;
                end
            end
            else if (mc == 0 && mb != 0)
            begin
                d = rev ? rift_differs(0, ob + 1, oa - mb + 1, mb, sb)
                        : rift_differs(0, ob - mb, oa, mb, sb);
                if (!d)
                begin
                    ma = -mb; mb = 0;
                end
            end
            r.miss_a = ma[13:0];
            r.miss_b = mb[13:0];
            r.garbage = mc[12:0];
            return r;
        endfunction

        function void note_input(logic [1:0] op, logic [11:0] idx, logic [15:0] smp,
                                 logic [12:0] sa, logic [12:0] sb,
                                 logic [11:0] oa, logic [11:0] ob);
            if (op == ara_pkg::OP_WRITE_A)
                store_a[idx] = smp;
            else if (op == ara_pkg::OP_WRITE_B)
                store_b[idx] = smp;
            else
                expected_rifts.push_back(locate_rift(op == ara_pkg::OP_ANALYZE_REV,
                                                     int'(sa), int'(sb),
                                                     int'(oa), int'(ob)));
        endfunction

        function void check_result(logic signed [13:0] ma, logic signed [13:0] mb,
                                   logic [12:0] mc);
            rift_result_t e;
            if (expected_rifts.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %0d %0d %0d", $time, ma, mb, mc);
                return;
            end
            e = expected_rifts.pop_front();
            if (ma !== e.miss_a)
            begin
                errors++;
                $display("%0t: match_a expected %0d actual %0d", $time, e.miss_a, ma);
            end
            if (mb !== e.miss_b)
            begin
                errors++;
                $display("%0t: match_b expected %0d actual %0d", $time, e.miss_b, mb);
            end
            if (mc !== e.garbage)
            begin
                errors++;
                $display("%0t: match_c expected %0d actual %0d", $time, e.garbage, mc);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         opcode;
    logic [11:0]        index;
    logic signed [15:0] sample;
    logic [12:0]        size_a;
    logic [12:0]        size_b;
    logic [11:0]        offset_a;
    logic [11:0]        offset_b;
    logic               out_valid;
    logic               out_stall;
    logic signed [13:0] match_a;
    logic signed [13:0] match_b;
    logic [12:0]        match_c;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [12:0]        cfg_min_run;

    rift_scoreboard sb = new();
    bit quiet = 0;
    int sent = 0;

    audio_rift_analyzer_core #(.BUFFER_SAMPLES(DEPTH)) uut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
        out_stall <= !quiet && ($urandom_range(99) < 6);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(match_a, match_b, match_c);

    task automatic send(logic [1:0] op, logic [11:0] idx, logic [15:0] smp,
                        logic [12:0] sa, logic [12:0] sb_n,
                        logic [11:0] oa, logic [11:0] ob);
        if (!quiet && $urandom_range(99) < 6)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        opcode <= op; index <= idx; sample <= smp;
        size_a <= sa; size_b <= sb_n; offset_a <= oa; offset_b <= ob;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(op, idx, smp, sa, sb_n, oa, ob);
        sent++;
    endtask

    task automatic analyze(bit rev, int sa, int sb_n, int oa, int ob);
        send(rev ? ara_pkg::OP_ANALYZE_REV : ara_pkg::OP_ANALYZE_FWD, 12'($urandom),
             16'($urandom), 13'(sa), 13'(sb_n), 12'(oa), 12'(ob));
    endtask

    task automatic write_sample(bit to_a, int idx, logic [15:0] v);
        send(to_a ? ara_pkg::OP_WRITE_A : ara_pkg::OP_WRITE_B, 12'(idx), v,
             13'($urandom), 13'($urandom), 12'($urandom), 12'($urandom));
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.expected_rifts.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_min_run(logic [12:0] v);
        drain();
        cfg_min_run <= v;
        cfg_valid <= 1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        sb.min_run = v;
    endtask

    // aligned run with one rift: dropped, repeated or garbage samples
    task automatic rift_sequence(int base);
        int p, k, t, kind, la, lb;
        logic [15:0] g [$];
        logic [15:0] qa [$];
        logic [15:0] qb [$];
        bit narrow;
        p = $urandom_range(0, 20);
        k = $urandom_range(1, 12);
        t = $urandom_range(4, 30);
        kind = $urandom_range(0, 5);
        narrow = ($urandom_range(3) == 0);
        for (int i = 0; i < p + k + t; i++)
            g.push_back(narrow ? 16'($urandom_range(0, 2)) : 16'($urandom));
        for (int i = 0; i < p; i++)
        begin
            qa.push_back(g[i]); qb.push_back(g[i]);
        end
        for (int i = 0; i < k; i++)
        begin
            case (kind)
                0: qa.push_back(g[p + i]);
                1: qb.push_back(g[p + i]);
                2:
                begin
                    qa.push_back(g[p + i]); qb.push_back(g[p + i]);
                    qb.push_back(p >= k ? g[p - k + i] : 16'($urandom));
                end
                3:
                begin
                    qa.push_back(g[p + i]); qb.push_back(g[p + i]);
                    qa.push_back(p >= k ? g[p - k + i] : 16'($urandom));
                end
                default:
                begin
                    qa.push_back(16'($urandom)); qb.push_back(16'($urandom));
                end
            endcase
        end
        for (int i = p + k; i < p + k + t; i++)
        begin
            qa.push_back(g[i]); qb.push_back(g[i]);
        end
        la = qa.size();
        lb = qb.size();
        foreach (qa[i]) write_sample(1, base + i, qa[i]);
        foreach (qb[i]) write_sample(0, base + i, qb[i]);
        analyze(0, base + la + ($urandom_range(3) == 0 ? $urandom_range(0, 4) : 0),
                base + lb + ($urandom_range(3) == 0 ? $urandom_range(0, 4) : 0),
                base + p, base + p);
        analyze(1, base + la, base + lb, base + $urandom_range(0, la - 1),
                base + $urandom_range(0, lb - 1));
    endtask

    task automatic random_phase(int count);
        int stop, r, oa, ob;
        stop = sent + count;
        while (sent < stop)
        begin
            quiet = (sent % 700) > 450 && (sent % 700) < 600;
            r = $urandom_range(99);
            if (r < 55)
                rift_sequence($urandom_range(0, 40));
            else if (r < 80)
                write_sample($urandom_range(1), $urandom_range(0, DEPTH - 1), 16'($urandom));
            else if (r < 90)
            begin
                oa = $urandom_range(0, 100);
                ob = $urandom_range(0, 100);
                analyze($urandom_range(1), oa + $urandom_range(0, 40),
                        ob + $urandom_range(0, 40), oa, ob);
            end
            else
            begin
                oa = $urandom_range(4030, 4095);
                ob = $urandom_range(4030, 4095);
                analyze(0, $urandom_range(4096, 8191), $urandom_range(4096, 8191), oa, ob);
            end
        end
        quiet = 0;
    endtask

    initial
    begin
        int waited;
        logic [12:0] run_lengths [7] = '{13'd16, 13'd5, 13'd1, 13'd0, 13'd8191, 13'd4096,
                                         13'd12};
        rst_n = 0;
        in_valid = 0; opcode = ara_pkg::OP_WRITE_A; index = 0; sample = 0;
        size_a = 0; size_b = 0; offset_a = 0; offset_b = 0;
        cfg_valid = 0; cfg_min_run = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // only the low and high ends of the stores are ever searched
        for (int i = 0; i < 256; i++)
        begin
            write_sample(1, i, 16'($urandom));
            write_sample(0, i, 16'($urandom));
        end
        for (int i = DEPTH - 128; i < DEPTH; i++)
        begin
            write_sample(1, i, 16'($urandom));
            write_sample(0, i, 16'($urandom));
        end

        // extremes and edge cases
        analyze(0, 0, 0, 0, 0);
        analyze(1, 0, 0, 0, 0);
        analyze(0, 8191, 8191, 4095, 4095);
        analyze(0, 4096, 5000, 4095, 4090);
        write_sample(1, 4095, 16'h8000);
        write_sample(0, 4095, 16'h8000);
        write_sample(1, 4094, 16'h7fff);
        write_sample(0, 4094, 16'h7fff);
        write_sample(1, 0, 16'h0000);
        write_sample(0, 0, 16'h0000);
        analyze(1, 8191, 8191, 255, 255);
        analyze(1, 13, 13, 0, 0);
        analyze(0, 20, 10, 15, 3);
        rift_sequence(0);
        rift_sequence(150);

        foreach (run_lengths[n])
        begin
            if (n != 0)
                set_min_run(run_lengths[n]);
            random_phase(n == 4 || n == 5 ? 80 : 120);
        end

        in_valid <= 0;
        waited = 0;
        while (sb.expected_rifts.size() != 0 && waited < 2_000_000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.expected_rifts.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
